/* rtl/core/pointer_cursor_tracker_macros.svh */
// Assertion macros shared by the cursor tracker RTL.
`ifndef POINTER_CURSOR_TRACKER_MACROS_SVH
`define POINTER_CURSOR_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCT_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("pointer cursor tracker check failed");

// Next-cycle implication, disabled during reset.
`define PCT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("pointer cursor tracker check failed");

`endif

/* rtl/core/pct_pkg.sv */
package pct_pkg;

	// Screen size
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;

	// Field widths
	localparam int CURSOR_X_W = 9;
	localparam int CURSOR_Y_W = 8;
	localparam int KEY_W      = 8;
	localparam int POT_W      = 8;
	localparam int PORT_W     = 5;

	// Signed width of the unclamped position sum (covers screens up to 1024)
	localparam int POS_SUM_W = 12;

	// Configuration register indexes
	localparam logic CFG_OVERRIDE_KEY  = 1'b0;
	localparam logic CFG_CURSOR_ENABLE = 1'b1;

	// Port bit positions (active low)
	localparam int PA_UP    = 0;
	localparam int PA_DOWN  = 1;
	localparam int PA_LEFT  = 2;
	localparam int PA_RIGHT = 3;
	localparam int PA_FIRE  = 4;
	localparam int PB_RMB   = 0;
	localparam int PB_FIRE  = 4;

	typedef struct packed {
		logic [POT_W-1:0]  pot_x;
		logic [POT_W-1:0]  pot_y;
		logic [PORT_W-1:0] port_a_bits;
		logic [PORT_W-1:0] port_b_bits;
		logic [KEY_W-1:0]  key_code;
		logic              key_taken;
	} pct_in_t;

	typedef struct packed {
		logic [CURSOR_X_W-1:0] cursor_x;
		logic [CURSOR_Y_W-1:0] cursor_y;
		logic                  left_button;
		logic [KEY_W-1:0]      pending_key;
		logic                  key_dequeue;
	} pct_out_t;

endpackage

/* rtl/core/pct_delta.sv */
module pct_delta (
	input  logic [pct_pkg::POT_W-1:0] pot,
	input  logic [pct_pkg::POT_W-1:0] last,
	output logic signed [7:0]         accel,
	output logic                      moved
);
	import pct_pkg::*;

	logic [POT_W-1:0]  diff;
	logic [6:0]        d;
	logic [7:0]        e;
	logic [7:0]        e_inc;
	logic signed [7:0] e_half;
	logic signed [5:0] raw;
	logic [5:0]        mag;

	// 7-bit difference, halved with sign, noise pattern dropped
	always_comb begin
		diff   = pot - last;
		d      = diff[6:0];
		e      = {2'b11, d[5:1], 1'b1};
		e_inc  = e + 8'd1;
		e_half = $signed(e_inc) >>> 1;
		if (!d[6]) begin
			raw = $signed({1'b0, d[5:1]});
		end else if (d[5:1] == 5'h1f) begin
			raw = 6'sd0;
		end else begin
			raw = e_half[5:0];
		end
	end

	// Acceleration: x4 above 15, x2 above 10
	always_comb begin
		mag = raw[5] ? 6'(-raw) : raw;
		if (mag > 6'd15) begin
			accel = {raw, 2'b00};
		end else if (mag > 6'd10) begin
			accel = {raw[5], raw, 1'b0};
		end else begin
			accel = {{2{raw[5]}}, raw};
		end
		moved = (raw != 6'sd0);
	end

endmodule

/* rtl/core/pct_key.sv */
module pct_key (
	input  logic [pct_pkg::KEY_W-1:0] key_code,
	input  logic                      key_taken,
	input  logic [pct_pkg::KEY_W-1:0] key_q,
	input  logic [pct_pkg::KEY_W-1:0] override_key,
	input  logic                      last_rmb,
	input  logic                      rmb,
	output logic [pct_pkg::KEY_W-1:0] key_next,
	output logic                      dequeue
);
	import pct_pkg::*;

	localparam logic [KEY_W-1:0] K_ESC    = 8'h1b;
	localparam logic [KEY_W-1:0] K_STOP   = 8'h03;
	localparam logic [KEY_W-1:0] K_F4     = 8'hf4;
	localparam logic [KEY_W-1:0] K_F1     = 8'hf1;
	localparam logic [KEY_W-1:0] K_F3     = 8'hf3;
	localparam logic [KEY_W-1:0] K_F5     = 8'hf5;
	localparam logic [KEY_W-1:0] K_F8     = 8'hf8;
	localparam logic [KEY_W-1:0] K_F9     = 8'hf9;
	localparam logic [KEY_W-1:0] K_LOWA   = 8'h61;
	localparam logic [KEY_W-1:0] K_LOWZ   = 8'h7a;
	localparam logic [KEY_W-1:0] K_LEFTAR = 8'h1f;
	localparam logic [KEY_W-1:0] K_SPACE  = 8'h20;
	localparam logic [KEY_W-1:0] K_RETURN = 8'h0d;
	localparam logic [KEY_W-1:0] K_LT     = 8'h3c;
	localparam logic [KEY_W-1:0] K_GT     = 8'h3e;

	logic [KEY_W-1:0] mapped;
	logic             hit;
	logic [KEY_W-1:0] kr;

	// Key code translation
	always_comb begin
		hit    = 1'b1;
		mapped = '0;
		if (key_code == K_ESC || key_code == K_STOP || key_code == K_F4) begin
			mapped = override_key;
		end else if (key_code == K_F1) begin
			mapped = 8'd1;
		end else if (key_code == K_F3) begin
			mapped = 8'd2;
		end else if (key_code == K_F5) begin
			mapped = 8'd3;
		end else if (key_code == K_F8) begin
			mapped = 8'd8;
		end else if (key_code == K_F9) begin
			mapped = 8'd5;
		end else if (key_code >= K_LOWA && key_code <= K_LOWZ) begin
			mapped = key_code;
		end else if (key_code == K_LEFTAR || key_code == K_SPACE || key_code == K_RETURN
				|| key_code == K_LT || key_code == K_GT) begin
			mapped = key_code;
		end else begin
			hit = 1'b0;
		end
	end

	// Pending key update; right button falling edge wins last
	always_comb begin
		kr      = key_taken ? '0 : key_q;
		dequeue = 1'b0;
		if (kr == '0) begin
			dequeue = 1'b1;
			if (key_code != '0 && hit) begin
				kr = mapped;
			end
		end
		if (last_rmb && !rmb) begin
			kr = override_key;
		end
		key_next = kr;
	end

endmodule

/* rtl/core/pointer_cursor_tracker.sv */
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid / in_stall  | in_data (pct_in_t)
// out     | out | out_valid / out_stall| out_data (pct_out_t)
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle while out_stall is low; each passes the input then the result register.
// All state (cursor, last pot bytes, buttons, key) updates as an item leaves the input register.
// A stalled result holds a full input register; in_stall is out_stall while both hold items.
// Reset clears the cursor, key and button state; cursor_enable resets to 1. cfg_ready is 1.
module pointer_cursor_tracker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  pct_pkg::pct_in_t         in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output pct_pkg::pct_out_t        out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [pct_pkg::KEY_W-1:0] cfg_data
);
	import pct_pkg::*;
	`include "pointer_cursor_tracker_macros.svh"

	localparam logic signed [POS_SUM_W-1:0] X_MAX = POS_SUM_W'(SCREEN_WIDTH - 1);
	localparam logic signed [POS_SUM_W-1:0] Y_MAX = POS_SUM_W'(SCREEN_HEIGHT - 1);
	localparam logic signed [POS_SUM_W-1:0] STEP  = POS_SUM_W'(2);

	// Handshake and pipeline
	logic     valid_s1;
	pct_in_t  in_s1;
	logic     valid_s2;
	pct_out_t out_s2;
	logic     adv2;
	logic     load1;
	logic     fire;

	// Configuration and state
	logic [KEY_W-1:0]      override_key_q;
	logic                  cursor_enable_q;
	logic [CURSOR_X_W-1:0] cursor_x_q;
	logic [CURSOR_Y_W-1:0] cursor_y_q;
	logic [POT_W-1:0]      last_pot_x_q;
	logic [POT_W-1:0]      last_pot_y_q;
	logic                  last_rmb_q;
	logic                  button_q;
	logic [KEY_W-1:0]      key_q;

	// Next-state values
	logic signed [7:0]           ax;
	logic signed [7:0]           ay;
	logic                        moved_x;
	logic                        moved_y;
	logic [KEY_W-1:0]            key_next;
	logic                        dequeue;
	logic signed [POS_SUM_W-1:0] jx;
	logic signed [POS_SUM_W-1:0] jy;
	logic signed [POS_SUM_W-1:0] nx;
	logic signed [POS_SUM_W-1:0] ny;
	logic [CURSOR_X_W-1:0]       x_next;
	logic [CURSOR_Y_W-1:0]       y_next;
	logic                        button_next;

	assign adv2      = !valid_s2 || !out_stall;
	assign load1     = !valid_s1 || adv2;
	assign fire      = valid_s1 && adv2;
	assign in_stall  = !load1;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	// Mouse deltas
	pct_delta u_delta_x (
		.pot   (in_s1.pot_x),
		.last  (last_pot_x_q),
		.accel (ax),
		.moved (moved_x)
	);

	pct_delta u_delta_y (
		.pot   (in_s1.pot_y),
		.last  (last_pot_y_q),
		.accel (ay),
		.moved (moved_y)
	);

	// Keyboard
	pct_key u_key (
		.key_code     (in_s1.key_code),
		.key_taken    (in_s1.key_taken),
		.key_q        (key_q),
		.override_key (override_key_q),
		.last_rmb     (last_rmb_q),
		.rmb          (in_s1.port_b_bits[PB_RMB]),
		.key_next     (key_next),
		.dequeue      (dequeue)
	);

	// Joystick steps, up over down and left over right
	always_comb begin
		jy = '0;
		if (!in_s1.port_a_bits[PA_UP]) begin
			jy = -STEP;
		end else if (!in_s1.port_a_bits[PA_DOWN]) begin
			jy = STEP;
		end
		jx = '0;
		if (!in_s1.port_a_bits[PA_LEFT]) begin
			jx = -STEP;
		end else if (!in_s1.port_a_bits[PA_RIGHT]) begin
			jx = STEP;
		end
	end

	// Position sum and clamp
	always_comb begin
		nx = $signed({{(POS_SUM_W-CURSOR_X_W){1'b0}}, cursor_x_q}) + jx;
		if (moved_x) begin
			nx = nx + POS_SUM_W'(ax);
		end
		ny = $signed({{(POS_SUM_W-CURSOR_Y_W){1'b0}}, cursor_y_q}) + jy;
		if (moved_y) begin
			ny = ny - POS_SUM_W'(ay);
		end
		if (nx < 0) begin
			x_next = '0;
		end else if (nx > X_MAX) begin
			x_next = X_MAX[CURSOR_X_W-1:0];
		end else begin
			x_next = nx[CURSOR_X_W-1:0];
		end
		if (ny < 0) begin
			y_next = '0;
		end else if (ny > Y_MAX) begin
			y_next = Y_MAX[CURSOR_Y_W-1:0];
		end else begin
			y_next = ny[CURSOR_Y_W-1:0];
		end
	end

	// Left button follows either fire input when enabled
	assign button_next = cursor_enable_q
		? (!in_s1.port_a_bits[PA_FIRE] || !in_s1.port_b_bits[PB_FIRE]) : button_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			override_key_q  <= '0;
			cursor_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OVERRIDE_KEY:  override_key_q  <= cfg_data;
				CFG_CURSOR_ENABLE: cursor_enable_q <= cfg_data[0];
				default:           override_key_q  <= override_key_q;
			endcase
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (load1 && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_s2.cursor_x    <= x_next;
			out_s2.cursor_y    <= y_next;
			out_s2.left_button <= button_next;
			out_s2.pending_key <= key_next;
			out_s2.key_dequeue <= dequeue;
		end
	end

	// Tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			last_pot_x_q <= '0;
			last_pot_y_q <= '0;
			last_rmb_q   <= 1'b0;
			button_q     <= 1'b0;
			key_q        <= '0;
		end else if (fire) begin
			cursor_x_q <= x_next;
			cursor_y_q <= y_next;
			if (moved_x) begin
				last_pot_x_q <= in_s1.pot_x;
			end
			if (moved_y) begin
				last_pot_y_q <= in_s1.pot_y;
			end
			last_rmb_q <= in_s1.port_b_bits[PB_RMB];
			button_q   <= button_next;
			key_q      <= key_next;
		end
	end

	// Checks
	`PCT_ASSERT_NOW(a_stall_has_item, clk, arst_n, in_stall, valid_s1 && valid_s2 && out_stall)
	`PCT_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire, out_valid)
	`PCT_ASSERT_NOW(a_x_on_screen, clk, arst_n, out_valid,
		{{(32-CURSOR_X_W){1'b0}}, out_data.cursor_x} < SCREEN_WIDTH)
	`PCT_ASSERT_NOW(a_y_on_screen, clk, arst_n, out_valid,
		{{(32-CURSOR_Y_W){1'b0}}, out_data.cursor_y} < SCREEN_HEIGHT)
	`PCT_ASSERT_NEXT(a_state_tracks_result, clk, arst_n, fire,
		out_data.cursor_x == cursor_x_q && out_data.pending_key == key_q)

endmodule

/* dv/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pct_pkg::*;

	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 8;

	// Keyboard codes the tracker maps
	localparam logic [7:0] KEY_ESC    = 8'h1b;
	localparam logic [7:0] KEY_STOP   = 8'h03;
	localparam logic [7:0] KEY_F4     = 8'hf4;
	localparam logic [7:0] KEY_F1     = 8'hf1;
	localparam logic [7:0] KEY_F3     = 8'hf3;
	localparam logic [7:0] KEY_F5     = 8'hf5;
	localparam logic [7:0] KEY_F8     = 8'hf8;
	localparam logic [7:0] KEY_F9     = 8'hf9;
	localparam logic [7:0] KEY_A      = 8'h61;
	localparam logic [7:0] KEY_Z      = 8'h7a;
	localparam logic [7:0] KEY_LARROW = 8'h1f;
	localparam logic [7:0] KEY_SPACE  = 8'h20;
	localparam logic [7:0] KEY_RETURN = 8'h0d;
	localparam logic [7:0] KEY_LT     = 8'h3c;
	localparam logic [7:0] KEY_GT     = 8'h3e;
	localparam logic [7:0] NO_KEY     = 8'h00;
	localparam logic [7:0] MAPPED_KEYS [15] = '{KEY_ESC, KEY_STOP, KEY_F4, KEY_F1, KEY_F3,
		KEY_F5, KEY_F8, KEY_F9, KEY_A, KEY_Z, KEY_LARROW, KEY_SPACE, KEY_RETURN, KEY_LT, KEY_GT};

	// Function key results
	localparam logic [7:0] F1_CODE = 8'd1;
	localparam logic [7:0] F3_CODE = 8'd2;
	localparam logic [7:0] F5_CODE = 8'd3;
	localparam logic [7:0] F8_CODE = 8'd8;
	localparam logic [7:0] F9_CODE = 8'd5;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	pct_in_t           in_data   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	pct_out_t          out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = CFG_OVERRIDE_KEY;
	logic [KEY_W-1:0]  cfg_data  = '0;

	// Tracker state as predicted, at its reset values
	logic [7:0]            ov_key   = 8'h00;
	logic                  en_fire  = 1'b1;
	logic [CURSOR_X_W-1:0] pos_x    = '0;
	logic [CURSOR_Y_W-1:0] pos_y    = '0;
	logic [7:0]            anchor_x = 8'h00;
	logic [7:0]            anchor_y = 8'h00;
	logic                  rmb_last = 1'b0;
	logic                  btn_held = 1'b0;
	logic [7:0]            key_held = 8'h00;

	pct_in_t  frame_q[$];
	pct_out_t report_q[$];
	pct_out_t want;

	int  fails = 0;
	int  frames_sent = 0;
	int  reports_seen = 0;
	int  settings_used = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;
	int  src_gap = 0;
	int  sink_gap = 0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	logic [7:0] walk_x = 8'h00;
	logic [7:0] walk_y = 8'h00;

	pointer_cursor_tracker uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// Signed motion from a pot byte, with the noise pattern dropped
	function automatic int pot_motion(logic [7:0] pot, logic [7:0] anchor);
		logic [6:0] d;
		logic [7:0] e;
		int v;
		d = 7'(pot - anchor);
		if (d < 7'd64)
			return int'(d >> 1);
		e = {1'b0, d} | 8'hc1;
		if (e == 8'hff)
			return 0;
		e = e + 8'd1;
		v = int'($signed(e));
		return v >>> 1;
	endfunction

	function automatic int accelerate(int v);
		int mag;
		mag = (v < 0) ? -v : v;
		if (mag > 15)
			return v * 4;
		if (mag > 10)
			return v * 2;
		return v;
	endfunction

	function automatic logic [7:0] key_map(logic [7:0] k, output bit hit);
		hit = 1'b1;
		case (k)
			KEY_ESC, KEY_STOP, KEY_F4: return ov_key;
			KEY_F1: return F1_CODE;
			KEY_F3: return F3_CODE;
			KEY_F5: return F5_CODE;
			KEY_F8: return F8_CODE;
			KEY_F9: return F9_CODE;
			KEY_LARROW, KEY_SPACE, KEY_RETURN, KEY_LT, KEY_GT: return k;
			default: ;
		endcase
		if (k >= KEY_A && k <= KEY_Z)
			return k;
		hit = 1'b0;
		return NO_KEY;
	endfunction

	// Advance the predicted tracker by one frame and return its report
	function automatic pct_out_t track_frame(pct_in_t s);
		int nx, ny, d;
		bit hit;
		logic [7:0] m;
		pct_out_t r;
		r = '0;
		nx = int'(pos_x);
		ny = int'(pos_y);
		// mouse
		d = pot_motion(s.pot_x, anchor_x);
		if (d != 0) begin
			nx += accelerate(d);
			anchor_x = s.pot_x;
		end
		d = pot_motion(s.pot_y, anchor_y);
		if (d != 0) begin
			ny -= accelerate(d);
			anchor_y = s.pot_y;
		end
		// keyboard
		if (s.key_taken)
			key_held = NO_KEY;
		if (key_held == NO_KEY) begin
			m = key_map(s.key_code, hit);
			if (s.key_code != NO_KEY && hit)
				key_held = m;
			r.key_dequeue = 1'b1;
		end
		// joystick, up and left win
		if (!s.port_a_bits[PA_UP])
			ny -= 2;
		else if (!s.port_a_bits[PA_DOWN])
			ny += 2;
		if (!s.port_a_bits[PA_LEFT])
			nx -= 2;
		else if (!s.port_a_bits[PA_RIGHT])
			nx += 2;
		if (en_fire)
			btn_held = !s.port_a_bits[PA_FIRE] || !s.port_b_bits[PB_FIRE];
		// right button falling edge overrides the key
		if (rmb_last && !s.port_b_bits[PB_RMB])
			key_held = ov_key;
		rmb_last = s.port_b_bits[PB_RMB];
		// clamp to screen
		if (nx < 0)
			nx = 0;
		else if (nx > SCREEN_WIDTH - 1)
			nx = SCREEN_WIDTH - 1;
		if (ny < 0)
			ny = 0;
		else if (ny > SCREEN_HEIGHT - 1)
			ny = SCREEN_HEIGHT - 1;
		pos_x = CURSOR_X_W'(nx);
		pos_y = CURSOR_Y_W'(ny);
		r.cursor_x = pos_x;
		r.cursor_y = pos_y;
		r.left_button = btn_held;
		r.pending_key = key_held;
		return r;
	endfunction

	function automatic pct_in_t frame_of(input logic [7:0] px, input logic [7:0] py,
			input logic [4:0] pa, input logic [4:0] pb, input logic [7:0] k, input logic t);
		pct_in_t s;
		s.pot_x = px;
		s.pot_y = py;
		s.port_a_bits = pa;
		s.port_b_bits = pb;
		s.key_code = k;
		s.key_taken = t;
		return s;
	endfunction

	// Mostly small pot moves, some wide moves and some jumps anywhere
	function automatic logic [7:0] next_pot(logic [7:0] p);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return 8'($urandom);
		if (pick < 5)
			return 8'(int'(p) + $urandom_range(0, 127));
		return 8'(int'(p) + $urandom_range(0, 24) - 12);
	endfunction

	function automatic pct_in_t random_frame();
		pct_in_t s;
		int pick;
		walk_x = next_pot(walk_x);
		walk_y = next_pot(walk_y);
		s.pot_x = walk_x;
		s.pot_y = walk_y;
		s.port_a_bits = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'h1f;
		if ($urandom_range(0, 3) == 0)
			s.port_b_bits = 5'($urandom);
		else
			s.port_b_bits = {4'hf, 1'($urandom_range(0, 2) != 0)};
		pick = $urandom_range(0, 9);
		if (pick < 3)
			s.key_code = MAPPED_KEYS[$urandom_range(0, 14)];
		else if (pick < 5)
			s.key_code = 8'(int'(KEY_A) + $urandom_range(0, 25));
		else if (pick < 7)
			s.key_code = NO_KEY;
		else
			s.key_code = 8'($urandom);
		s.key_taken = 1'($urandom_range(0, 1));
		return s;
	endfunction

	// Both registers are written back to back; valid stays high across the pair
	task automatic write_config(logic [7:0] key, logic en);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_OVERRIDE_KEY;
		cfg_data  <= key;
		do @(posedge clk); while (!cfg_ready);
		ov_key = key;
		cfg_index <= CFG_CURSOR_ENABLE;
		cfg_data  <= {7'd0, en};
		do @(posedge clk); while (!cfg_ready);
		en_fire = en;
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (frame_q.size() != 0 || in_valid || report_q.size() != 0);
	endtask

	task automatic queue_random(int n);
		repeat (n) frame_q.push_back(random_frame());
	endtask

	// Request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				report_q.push_back(track_frame(in_data));
				frames_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (frame_q.size() != 0) begin
					in_data  <= frame_q.pop_front();
					in_valid <= 1'b1;
					if (idle_on && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				reports_seen++;
				if (report_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					fails++;
				end else begin
					want = report_q.pop_front();
					if (out_data.cursor_x !== want.cursor_x) begin
						$display("%0t: cursor_x expected %0d got %0d", $time,
							want.cursor_x, out_data.cursor_x);
						fails++;
					end
					if (out_data.cursor_y !== want.cursor_y) begin
						$display("%0t: cursor_y expected %0d got %0d", $time,
							want.cursor_y, out_data.cursor_y);
						fails++;
					end
					if (out_data.left_button !== want.left_button) begin
						$display("%0t: left_button expected %0b got %0b", $time,
							want.left_button, out_data.left_button);
						fails++;
					end
					if (out_data.pending_key !== want.pending_key) begin
						$display("%0t: pending_key expected %02h got %02h", $time,
							want.pending_key, out_data.pending_key);
						fails++;
					end
					if (out_data.key_dequeue !== want.key_dequeue) begin
						$display("%0t: key_dequeue expected %0b got %0b", $time,
							want.key_dequeue, out_data.key_dequeue);
						fails++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (idle_on && $urandom_range(0, 7) == 0)
					sink_gap = $urandom_range(1, 9);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("pointer_cursor_tracker regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: pot noise, acceleration, clamps, joystick, keys, right button edges
		write_config(8'hff, 1'b1);
		frame_q.push_back(frame_of(8'h3f, 8'h00, 5'h1f, 5'h1f, KEY_ESC, 1'b0));
		frame_q.push_back(frame_of(8'h7e, 8'h00, 5'h1f, 5'h1f, KEY_STOP, 1'b0));
		frame_q.push_back(frame_of(8'hbd, 8'h00, 5'h1f, 5'h1f, KEY_F4, 1'b1));
		frame_q.push_back(frame_of(8'hbe, 8'h00, 5'h1f, 5'h1f, KEY_F1, 1'b1));
		frame_q.push_back(frame_of(8'h3c, 8'h00, 5'h1f, 5'h1f, KEY_F3, 1'b1));
		frame_q.push_back(frame_of(8'hfd, 8'h00, 5'h1f, 5'h1f, KEY_F5, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h00, 5'h1f, 5'h1f, KEY_F8, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h40, 5'h1f, 5'h1f, KEY_F9, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h56, 5'h1f, 5'h1f, KEY_A, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h60, 5'h1f, 5'h1f, KEY_Z, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h9f, 5'h1f, 5'h1f, KEY_LARROW, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'he0, 5'h1f, 5'h1f, KEY_SPACE, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h21, 5'h1f, 5'h1f, KEY_RETURN, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h21, 5'h00, 5'h1f, KEY_LT, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h21, 5'h15, 5'h1f, KEY_GT, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h21, 5'h1f, 5'h0f, 8'h60, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h21, 5'h1f, 5'h1e, 8'h7b, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h21, 5'h1f, 5'h1f, 8'hf2, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h21, 5'h1f, 5'h1e, 8'hfe, 1'b1));
		frame_q.push_back(frame_of(8'h7a, 8'h21, 5'h1f, 5'h1f, NO_KEY, 1'b1));
		frame_q.push_back(frame_of(8'hff, 8'hff, 5'h1f, 5'h1f, 8'hff, 1'b0));
		frame_q.push_back(frame_of(8'h00, 8'h00, 5'h1f, 5'h1f, NO_KEY, 1'b0));
		wait_drained();

		// random phases across register settings
		write_config(8'h00, 1'b0);
		queue_random(300);
		wait_drained();

		// long receiver hold while requests keep coming
		write_config(8'($urandom), 1'b1);
		queue_random(400);
		hold_req = 1'b1;
		wait_drained();

		write_config(8'($urandom), 1'b0);
		queue_random(350);
		wait_drained();

		// closing stretch at full rate
		idle_on = 1'b0;
		write_config(KEY_ESC, 1'b1);
		queue_random(400);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d frames sent, %0d reports checked, %0d register settings", frames_sent,
			reports_seen, settings_used);
		$display("pot noise, acceleration, clamps, joystick, fire, key mapping, button edges");
		if (fails == 0)
			$display("pointer_cursor_tracker regression: pass");
		else
			$display("pointer_cursor_tracker regression: fail");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pct_pkg.sv
rtl/core/pct_delta.sv
rtl/core/pct_key.sv
rtl/core/pointer_cursor_tracker.sv
dv/testbench.sv
